[rtl/hcd_pkg.sv]
// shared constants and types for the chunked body decoder
// parse phase codes, error codes, byte codes and the result beat struct
// no dependencies
package hcd_pkg;

  localparam int LEN_WIDTH = 32;
  localparam int OVF_BITS  = 5;

  localparam logic [2:0] PH_LEN      = 3'd0;
  localparam logic [2:0] PH_MORE_LEN = 3'd1;
  localparam logic [2:0] PH_EXT      = 3'd2;
  localparam logic [2:0] PH_DATA     = 3'd3;
  localparam logic [2:0] PH_END      = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;
  localparam logic [2:0] PH_ERROR    = 3'd6;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_FIRST_HEX = 3'd1;
  localparam logic [2:0] ERR_LEN_CHAR  = 3'd2;
  localparam logic [2:0] ERR_NO_LF     = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;
  localparam logic [2:0] ERR_NO_CR     = 3'd5;
  localparam logic [2:0] ERR_AFTER_END = 3'd6;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_payload;
    logic       body_done;
    logic       error_flag;
    logic [2:0] error_code;
  } hcd_result_t;

endpackage

[rtl/hcd_in_if.sv]
// input channel of the chunked body decoder: one raw body byte per beat
// depends on nothing
interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[rtl/hcd_out_if.sv]
// result channel of the chunked body decoder: one decoded byte and flags per beat
// depends on nothing
interface hcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_payload;
  logic       body_done;
  logic       error_flag;
  logic [2:0] error_code;

  modport source (output valid, output out_byte, output is_payload, output body_done,
                  output error_flag, output error_code, input ready);
  modport sink (input valid, input out_byte, input is_payload, input body_done,
                input error_flag, input error_code, output ready);
endinterface

[rtl/http_chunked_decoder_unit.sv]
// http chunked transfer decoder, one body byte per beat
//
// channels: body (sink) takes raw bytes of a chunked-encoded body; result
// (source) gives one beat per input byte: the byte echoed, a payload mark,
// body_done and a sticky error flag with its code.
// path: a byte taken from body is held in the input register, then runs
// through the parser into the result register, from which result offers it.
// throughput: one byte per cycle unless stalled; the parser state update is a
// single pass of hex decode, a length shift or decrement and the phase select.
// reset (rst, synchronous): both registers empty, parser back to waiting for
// the first length digit, no error held.
// stall: while result is not taken the result register holds its beat; the
// input register still takes one more byte, then body.ready drops until the
// result beat leaves. nothing is dropped or repeated.
// depends on hcd_pkg, hcd_in_if, hcd_out_if, hcd_parser
module http_chunked_decoder_unit
  import hcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hcd_in_if.sink     body,
  hcd_out_if.source  result
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        res_valid;
  hcd_result_t res_data;
  hcd_result_t step_res;
  logic        advance;

  assign advance    = in_valid && (!res_valid || result.ready);
  assign body.ready = !in_valid || advance;

  hcd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .data (in_byte),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (body.ready) begin
      in_valid <= body.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (body.valid && body.ready) in_byte <= body.in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_data <= step_res;
  end

  assign result.valid      = res_valid;
  assign result.out_byte   = res_data.out_byte;
  assign result.is_payload = res_data.is_payload;
  assign result.body_done  = res_data.body_done;
  assign result.error_flag = res_data.error_flag;
  assign result.error_code = res_data.error_code;

  a_err_code_set: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.error_flag |-> result.error_code != ERR_NONE)
    else $error("error beat without an error code");

  a_err_code_clear: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.error_flag |-> result.error_code == ERR_NONE)
    else $error("error code on a clean beat");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.is_payload |-> !result.error_flag && !result.body_done)
    else $error("payload beat marked done or in error");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && result.error_flag ##1 result.valid
      |-> result.error_flag)
    else $error("error flag cleared after an error beat");

endmodule

[rtl/hcd_parser.sv]
// byte-wide parser state and its next-state logic for the chunked body decoder
// depends on hcd_pkg
module hcd_parser
  import hcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data,
  output hcd_result_t res
);

  logic [2:0]           parse_phase, parse_phase_next;
  logic                 pending_cr, pending_cr_next;
  logic                 line_empty, line_empty_next;
  logic [LEN_WIDTH-1:0] bytes_left, bytes_left_next;
  logic [2:0]           held_error, held_error_next;

  logic       is_hex;
  logic [3:0] digit;
  logic       payload;
  logic       err;
  logic       done;

  // hex digit decode, either letter case
  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (data >= 8'h30 && data <= 8'h39) begin
      digit = data[3:0];
    end else if ((data >= 8'h61 && data <= 8'h66) || (data >= 8'h41 && data <= 8'h46)) begin
      digit = data[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    parse_phase_next = parse_phase;
    pending_cr_next  = pending_cr;
    line_empty_next  = line_empty;
    bytes_left_next  = bytes_left;
    held_error_next  = held_error;
    payload          = 1'b0;
    unique case (parse_phase)
      PH_LEN: begin
        pending_cr_next = 1'b0;
        if (!is_hex) begin
          held_error_next  = ERR_FIRST_HEX;
          parse_phase_next = PH_ERROR;
        end else begin
          bytes_left_next  = {{(LEN_WIDTH-4){1'b0}}, digit};
          parse_phase_next = PH_MORE_LEN;
        end
      end
      PH_MORE_LEN, PH_EXT: begin
        pending_cr_next = 1'b0;
        if (pending_cr) begin
          if (data != CH_LF) begin
            held_error_next  = ERR_NO_LF;
            parse_phase_next = PH_ERROR;
          end else if (bytes_left == '0) begin
            line_empty_next  = 1'b1;
            parse_phase_next = PH_END;
          end else begin
            parse_phase_next = PH_DATA;
          end
        end else if (parse_phase == PH_EXT) begin
          if (data == CH_CR) pending_cr_next = 1'b1;
        end else if (!is_hex) begin
          if (data == CH_SEMI) begin
            parse_phase_next = PH_EXT;
          end else if (data == CH_CR) begin
            pending_cr_next = 1'b1;
          end else begin
            held_error_next  = ERR_LEN_CHAR;
            parse_phase_next = PH_ERROR;
          end
        end else if (|bytes_left[LEN_WIDTH-1 -: OVF_BITS]) begin
          held_error_next  = ERR_OVERFLOW;
          parse_phase_next = PH_ERROR;
        end else begin
          bytes_left_next = {bytes_left[LEN_WIDTH-5:0], digit};
        end
      end
      PH_DATA: begin
        if (bytes_left != '0) begin
          payload         = 1'b1;
          bytes_left_next = bytes_left - 1'b1;
        end else if (!pending_cr) begin
          if (data != CH_CR) begin
            held_error_next  = ERR_NO_CR;
            parse_phase_next = PH_ERROR;
          end else begin
            pending_cr_next = 1'b1;
          end
        end else begin
          pending_cr_next = 1'b0;
          if (data != CH_LF) begin
            held_error_next  = ERR_NO_LF;
            parse_phase_next = PH_ERROR;
          end else begin
            parse_phase_next = PH_LEN;
          end
        end
      end
      PH_END: begin
        pending_cr_next = 1'b0;
        if (pending_cr) begin
          if (data != CH_LF) begin
            held_error_next  = ERR_NO_LF;
            parse_phase_next = PH_ERROR;
          end else if (line_empty) begin
            parse_phase_next = PH_DONE;
          end else begin
            line_empty_next = 1'b1;
          end
        end else if (data == CH_CR) begin
          pending_cr_next = 1'b1;
        end else begin
          line_empty_next = 1'b0;
        end
      end
      PH_DONE: begin
        held_error_next  = ERR_AFTER_END;
        parse_phase_next = PH_ERROR;
        pending_cr_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // the error code and the unused code above it both count as error state
  assign err  = (parse_phase_next > PH_DONE);
  assign done = (parse_phase_next == PH_DONE) ||
                (parse_phase_next == PH_ERROR && held_error_next == ERR_AFTER_END);

  always_comb begin
    res.out_byte   = data;
    res.is_payload = payload;
    res.body_done  = done;
    res.error_flag = err;
    res.error_code = err ? held_error_next : ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_LEN;
      pending_cr  <= 1'b0;
      line_empty  <= 1'b0;
      bytes_left  <= '0;
      held_error  <= ERR_NONE;
    end else if (step) begin
      parse_phase <= parse_phase_next;
      pending_cr  <= pending_cr_next;
      line_empty  <= line_empty_next;
      bytes_left  <= bytes_left_next;
      held_error  <= held_error_next;
    end
  end

endmodule

[test/tb_http_chunked_decoder_unit.sv]
// self-checking testbench for http_chunked_decoder_unit: one random chunked body per run,
// with random idles and stalls on both channels, checked beat by beat against a predictor
// depends on hcd_pkg, hcd_in_if, hcd_out_if and the decoder rtl
module tb_http_chunked_decoder_unit;
  import hcd_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  class chunk_decode_scoreboard;
    logic [2:0]           phase;
    bit                   pend_cr;
    bit                   line_empty;
    logic [LEN_WIDTH-1:0] remaining;
    logic [2:0]           held_code;
    hcd_result_t          due_results[$];
    int                   errors;
    int                   payload_seen;

    function new();
      phase      = PH_LEN;
      pend_cr    = 0;
      line_empty = 0;
      remaining  = '0;
      held_code  = ERR_NONE;
    endfunction

    static function int hex_val(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
    endfunction

    function void fail(logic [2:0] code);
      held_code = code;
      phase     = PH_ERROR;
      pend_cr   = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // advance the parser by one accepted byte and queue the beat it must produce
    function void predict_byte(logic [7:0] c);
      hcd_result_t want;
      bit          had;
      bit          payload;
      int          d;
      logic [3:0]  nib;
      had     = pend_cr;
      payload = 0;
      d       = hex_val(c);
      nib     = d[3:0];
      case (phase)
        PH_LEN: begin
          pend_cr = 0;
          if (d < 0) fail(ERR_FIRST_HEX);
          else begin
            remaining = LEN_WIDTH'(nib);
            phase     = PH_MORE_LEN;
          end
        end
        PH_MORE_LEN: begin
          pend_cr = 0;
          if (had) begin
            if (c != CH_LF) fail(ERR_NO_LF);
            else if (remaining == 0) begin
              line_empty = 1;
              phase      = PH_END;
            end else phase = PH_DATA;
          end else if (d < 0) begin
            if (c == CH_SEMI) phase = PH_EXT;
            else if (c == CH_CR) pend_cr = 1;
            else fail(ERR_LEN_CHAR);
          end else if (remaining[LEN_WIDTH-1 -: OVF_BITS] != 0) begin
            fail(ERR_OVERFLOW);
          end else begin
            remaining = {remaining[LEN_WIDTH-5:0], nib};
          end
        end
        PH_EXT: begin
          pend_cr = 0;
          if (had) begin
            if (c != CH_LF) fail(ERR_NO_LF);
            else if (remaining == 0) begin
              line_empty = 1;
              phase      = PH_END;
            end else phase = PH_DATA;
          end else if (c == CH_CR) pend_cr = 1;
        end
        PH_DATA: begin
          if (remaining != 0) begin
            payload   = 1;
            remaining = remaining - 1;
          end else if (!had) begin
            if (c != CH_CR) fail(ERR_NO_CR);
            else pend_cr = 1;
          end else begin
            pend_cr = 0;
            if (c != CH_LF) fail(ERR_NO_LF);
            else phase = PH_LEN;
          end
        end
        PH_END: begin
          pend_cr = 0;
          if (had) begin
            if (c != CH_LF) fail(ERR_NO_LF);
            else if (line_empty) phase = PH_DONE;
            else line_empty = 1;
          end else if (c == CH_CR) pend_cr = 1;
          else line_empty = 0;
        end
        PH_DONE: fail(ERR_AFTER_END);
        default: ;
      endcase
      want.out_byte   = c;
      want.is_payload = payload;
      want.body_done  = (phase == PH_DONE) || (phase == PH_ERROR && held_code == ERR_AFTER_END);
      want.error_flag = (phase > PH_DONE);
      want.error_code = (phase > PH_DONE) ? held_code : ERR_NONE;
      due_results.push_back(want);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(hcd_result_t got);
      hcd_result_t want;
      if (due_results.size() == 0) begin
        $error("result beat 0x%02h with no byte waiting", got.out_byte);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.is_payload === 1'b1) payload_seen++;
      compare("out_byte", want.out_byte, got.out_byte);
      compare("is_payload", 8'(want.is_payload), 8'(got.is_payload));
      compare("body_done", 8'(want.body_done), 8'(got.body_done));
      compare("error_flag", 8'(want.error_flag), 8'(got.error_flag));
      compare("error_code", 8'(want.error_code), 8'(got.error_code));
    endfunction
  endclass

  logic clk;
  logic rst;

  hcd_in_if  body_ch();
  hcd_out_if result_ch();

  http_chunked_decoder_unit dut (
    .clk    (clk),
    .rst    (rst),
    .body   (body_ch),
    .result (result_ch)
  );

  chunk_decode_scoreboard tracker;
  hcd_result_t            seen;
  int                     bytes_sent;
  int                     chunks_sent;
  int                     idle_cycles;
  int                     rx_hold;
  bit                     rx_steady;
  bit                     tx_steady;
  logic [2:0]             end_code;

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(int nib);
    if (nib < 10) return 8'(48 + nib);
    if ($urandom_range(0, 1)) return 8'(65 + nib - 10);
    return 8'(97 + nib - 10);
  endfunction

  function automatic logic [7:0] rand_byte_except(logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom); while (b == avoid);
    return b;
  endfunction

  function automatic logic [7:0] rand_non_hex(bit as_len_char);
    logic [7:0] b;
    do b = 8'($urandom);
    while (chunk_decode_scoreboard::hex_val(b) >= 0 ||
           (as_len_char && (b == CH_SEMI || b == CH_CR)));
    return b;
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if ($urandom_range(0, 59) == 0) tx_steady = !tx_steady;
    @(negedge clk);
    if (gap > 0) begin
      body_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    body_ch.valid   <= 1'b1;
    body_ch.in_byte <= b;
    do @(posedge clk); while (!body_ch.ready);
    tracker.predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // length line: optional leading zeros, mixed-case hex, optional extension
  task automatic send_len(int n, bit with_ext);
    int zeros;
    int nd;
    zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 0;
    repeat (zeros) send_byte(8'h30);
    nd = 1;
    while (nd < 8 && (n >> (4 * nd)) != 0) nd++;
    for (int i = nd - 1; i >= 0; i--) send_byte(hex_char((n >> (4 * i)) & 15));
    if (with_ext) begin
      send_byte(CH_SEMI);
      repeat ($urandom_range(0, 6)) send_byte(rand_byte_except(CH_CR));
    end
    send_crlf();
  endtask

  task automatic send_chunk(int n);
    send_len(n, $urandom_range(0, 3) == 0);
    repeat (n) send_byte(8'($urandom));
    send_crlf();
    chunks_sent++;
  endtask

  task automatic send_trailer();
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 6)) send_byte(rand_byte_except(CH_CR));
      send_crlf();
    end
    send_crlf();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    body_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // result side: random stalls, with stretches of steady ready
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      result_ch.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      result_ch.ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 2) == 0) rx_hold = pick_gap();
    end
    if ($urandom_range(0, 79) == 0) rx_steady = !rx_steady;
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen.out_byte   = result_ch.out_byte;
      seen.is_payload = result_ch.is_payload;
      seen.body_done  = result_ch.body_done;
      seen.error_flag = result_ch.error_flag;
      seen.error_code = result_ch.error_code;
      tracker.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if ((body_ch.valid && body_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no beat moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    int n;
    clk             = 1'b0;
    rst             = 1'b1;
    body_ch.valid   = 1'b0;
    body_ch.in_byte = 8'h00;
    result_ch.ready = 1'b0;
    rx_hold         = 0;
    rx_steady       = 0;
    tx_steady       = 0;
    idle_cycles     = 0;
    bytes_sent      = 0;
    chunks_sent     = 0;
    tracker         = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extension with a quote, payload extremes, payload bytes that look like framing
    send_str("0002;\"");
    send_crlf();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_crlf();
    send_str("3");
    send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_SEMI);
    send_crlf();
    chunks_sent = 2;
    wait_drained();

    while (bytes_sent < 560) begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 8);
      else if (r < 96) n = $urandom_range(9, 40);
      else n = $urandom_range(64, 200);
      send_chunk(n);
      if ($urandom_range(0, 24) == 0) wait_drained();
    end

    // one way for the body to end per run, picked by the seed
    end_code = 3'($urandom_range(ERR_FIRST_HEX, ERR_AFTER_END));
    case (end_code)
      ERR_FIRST_HEX: send_byte(rand_non_hex(0));
      ERR_LEN_CHAR: begin
        send_byte(hex_char($urandom_range(0, 15)));
        send_byte(rand_non_hex(1));
      end
      ERR_NO_LF: begin
        case ($urandom_range(0, 3))
          0: send_str("1");
          1: send_str("1;x");
          2: begin
            send_str("1");
            send_crlf();
            send_byte(8'($urandom));
          end
          default: begin
            send_str("0");
            send_crlf();
            send_str("ab");
          end
        endcase
        send_byte(CH_CR);
        send_byte(rand_byte_except(CH_LF));
      end
      ERR_OVERFLOW: begin
        send_byte(hex_char(7));
        repeat (7) send_byte(hex_char(15));
        send_byte(hex_char($urandom_range(0, 15)));
      end
      ERR_NO_CR: begin
        send_str("2");
        send_crlf();
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(rand_byte_except(CH_CR));
      end
      default: begin
        send_len(0, 1'($urandom_range(0, 1)));
        send_trailer();
        send_byte(8'($urandom));
      end
    endcase
    repeat (30) send_byte(8'($urandom));

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d result beats never arrived", tracker.pending());
      tracker.errors++;
    end

    $display("sent %0d body bytes in %0d chunks, %0d payload bytes came back",
             bytes_sent, chunks_sent, tracker.payload_seen);
    $display("body ended by error code %0d, then noise bytes on the held error", end_code);
    if (tracker.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/hcd_pkg.sv
rtl/hcd_in_if.sv
rtl/hcd_out_if.sv
rtl/hcd_parser.sv
rtl/http_chunked_decoder_unit.sv
test/tb_http_chunked_decoder_unit.sv
